// ----- hw/rtl/ptb_pkg.sv -----
package ptb_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = 5;

  typedef enum logic {
    OP_CREATE = 1'b0,
    OP_CHECK  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CREATED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_FIRED   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // command fields held for the whole walk, seen by every cell
  typedef struct packed {
    opcode_t     op;
    logic [63:0] now;
    logic [63:0] period;
    logic [7:0]  count;
    logic [7:0]  task_num;
    logic [31:0] serial;
  } cmd_t;

  // token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic             act;
    logic             claimed;
    logic [CNT_W-1:0] n_fired;
  } tok_t;

  // event raised by the cell holding the token
  typedef struct packed {
    logic        v;
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] serial;
    logic [7:0]  task_num;
  } ev_t;

endpackage

// ----- hw/rtl/ptb_cell.sv -----
module ptb_cell #(
  parameter int unsigned SLOT_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ptb_pkg::cmd_t cmd,
  input  ptb_pkg::tok_t tok_in,
  output ptb_pkg::tok_t tok_out,
  output ptb_pkg::ev_t  ev
);
  import ptb_pkg::*;

  tok_t        tok_r;
  ev_t         ev_r, ev_nxt;
  logic        valid_r, valid_nxt;
  logic [63:0] dl_r, dl_nxt;
  logic [63:0] per_r, per_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  task_r, task_nxt;
  logic [31:0] id_r, id_nxt;
  logic        hit_create, hit_fire;
  logic [63:0] reload;

  always_comb begin
    hit_create = tok_r.act && (cmd.op == OP_CREATE) && !tok_r.claimed && !valid_r;
    hit_fire   = tok_r.act && (cmd.op == OP_CHECK) && valid_r && (cmd.now >= dl_r)
                 && (tok_r.n_fired != CNT_W'(MAX_RESULTS));
    reload     = cmd.now + (hit_create ? cmd.period : per_r);

    tok_out         = tok_r;
    tok_out.claimed = tok_r.claimed | hit_create;
    tok_out.n_fired = tok_r.n_fired + {{(CNT_W-1){1'b0}}, hit_fire};

    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    per_nxt   = per_r;
    cnt_nxt   = cnt_r;
    task_nxt  = task_r;
    id_nxt    = id_r;
    ev_nxt    = '0;

    if (hit_create) begin
      valid_nxt       = 1'b1;
      dl_nxt          = reload;
      per_nxt         = cmd.period;
      cnt_nxt         = cmd.count;
      task_nxt        = cmd.task_num;
      id_nxt          = cmd.serial;
      ev_nxt.v        = 1'b1;
      ev_nxt.kind     = KIND_CREATED;
      ev_nxt.slot     = 4'(SLOT_IDX);
      ev_nxt.serial   = cmd.serial;
      ev_nxt.task_num = 8'd0;
    end else if (hit_fire) begin
      dl_nxt          = reload;
      ev_nxt.v        = 1'b1;
      ev_nxt.kind     = KIND_FIRED;
      ev_nxt.slot     = 4'(SLOT_IDX);
      ev_nxt.serial   = id_r;
      ev_nxt.task_num = task_r;
      if (cnt_r == 8'd1) begin
        valid_nxt = 1'b0;
      end else if (cnt_r != 8'd0) begin
        cnt_nxt = cnt_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      ev_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      tok_r   <= tok_in;
      ev_r    <= ev_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r   <= dl_nxt;
    per_r  <= per_nxt;
    cnt_r  <= cnt_nxt;
    task_r <= task_nxt;
    id_r   <= id_nxt;
  end

  assign ev = ev_r;

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit_create && hit_fire))
    else $error("cell both creates and fires");

  a_cap_kept: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r.act |-> (tok_r.n_fired <= CNT_W'(MAX_RESULTS)))
    else $error("fired count beyond cap");

  a_create_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hit_create |=> valid_r)
    else $error("created slot not valid");

endmodule

// ----- hw/rtl/periodic_timer_bank_core.sv -----
// Each beat walks a token down the chain of slot cells, one cell per clock.
// Results stream during the walk; the final beat (last = 1) follows it, after which busy
// drops, so a new beat is accepted only once the previous one has finished.
// Fired results leave in slot order, at most one per cycle; the receiver cannot stall.
// Reset (sync, active low) clears every slot's valid bit, the serial counter and control.
module periodic_timer_bank_core #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [63:0] in_now,
  input  logic [63:0] in_period,
  input  logic [7:0]  in_repeat_count,
  input  logic [7:0]  in_task_number,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [31:0] out_serial_id,
  output logic [7:0]  out_fired_task,
  output logic        out_last
);
  import ptb_pkg::*;

  logic                   busy_r, busy_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [31:0]            serial_r, serial_nxt;
  logic                   pend_v_r, pend_v_nxt;
  ev_t                    pend_r, pend_nxt;
  logic                   end_r, end_d_r;
  logic                   accept;
  tok_t [NUM_SLOTS:0]     chain;
  ev_t  [NUM_SLOTS-1:0]   cell_ev;
  ev_t                    ev_any;
  logic [NUM_SLOTS-1:0]   act_vec, evv_vec;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign chain[0] = '{act: accept, claimed: 1'b0, n_fired: '0};

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptb_cell #(.SLOT_IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .ev      (cell_ev[i])
    );
    assign act_vec[i] = chain[i+1].act;
    assign evv_vec[i] = cell_ev[i].v;
  end

  always_comb begin
    ev_any = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ev_any = ev_t'(ev_any | cell_ev[i]);
    end
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    busy_nxt   = busy_r;
    serial_nxt = serial_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (accept) begin
      cmd_nxt.op       = opcode_t'(in_opcode);
      cmd_nxt.now      = in_now;
      cmd_nxt.period   = in_period;
      cmd_nxt.count    = in_repeat_count;
      cmd_nxt.task_num = in_task_number;
      cmd_nxt.serial   = serial_r;
      busy_nxt         = 1'b1;
      pend_v_nxt       = 1'b0;
    end else if (ev_any.v) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = ev_any;
      if (ev_any.kind == KIND_CREATED) begin
        serial_nxt = serial_r + 32'd1;
      end
    end else if (end_d_r) begin
      pend_v_nxt = 1'b0;
      busy_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid = (ev_any.v && pend_v_r) || end_d_r;
    out_last  = end_d_r;
    if (pend_v_r) begin
      out_kind       = pend_r.kind;
      out_slot       = pend_r.slot;
      out_serial_id  = pend_r.serial;
      out_fired_task = pend_r.task_num;
    end else begin
      out_kind       = (cmd_r.op == OP_CREATE) ? KIND_FULL : KIND_NONE;
      out_slot       = 4'd0;
      out_serial_id  = 32'd0;
      out_fired_task = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      serial_r <= 32'd0;
      pend_v_r <= 1'b0;
      end_r    <= 1'b0;
      end_d_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      serial_r <= serial_nxt;
      pend_v_r <= pend_v_nxt;
      end_r    <= chain[NUM_SLOTS].act;
      end_d_r  <= end_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
  end

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(act_vec))
    else $error("more than one cell holds the token");

  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(evv_vec))
    else $error("more than one cell raised an event");

  a_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result beat while idle");

  a_final_alone: assert property (@(posedge clk) disable iff (!rst_n)
    end_d_r |-> !ev_any.v)
    else $error("event arrived with the final beat");

  a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    end_d_r |=> !busy_r)
    else $error("busy held after final beat");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptb_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  localparam logic [63:0] TICK_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] serial;
    logic [7:0]  task_num;
    logic        last;
  } timer_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [63:0] in_now;
  logic [63:0] in_period;
  logic [7:0]  in_repeat_count;
  logic [7:0]  in_task_number;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [3:0]  out_slot;
  logic [31:0] out_serial_id;
  logic [7:0]  out_fired_task;
  logic        out_last;

  // predictor copy of the timer bank
  logic        tm_valid    [NUM_SLOTS];
  logic [63:0] tm_deadline [NUM_SLOTS];
  logic [63:0] tm_period   [NUM_SLOTS];
  logic [7:0]  tm_left     [NUM_SLOTS];
  logic [7:0]  tm_task     [NUM_SLOTS];
  logic [31:0] tm_serial   [NUM_SLOTS];
  logic [31:0] serial_ctr;

  timer_result_t pending_results[$];
  int unsigned   mismatch_count;
  bit            idle_enable;
  logic [63:0]   tick;

  periodic_timer_bank_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_now          (in_now),
    .in_period       (in_period),
    .in_repeat_count (in_repeat_count),
    .in_task_number  (in_task_number),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_slot        (out_slot),
    .out_serial_id   (out_serial_id),
    .out_fired_task  (out_fired_task),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  task automatic predict_timers(opcode_t op, logic [63:0] now, logic [63:0] period,
                                logic [7:0] cnt, logic [7:0] tsk);
    timer_result_t batch[MAX_RESULTS];
    int            n;
    int            free_slot;
    n = 0;
    free_slot = -1;
    if (op == OP_CREATE) begin
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (!tm_valid[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        tm_valid[free_slot]    = 1'b1;
        tm_deadline[free_slot] = now + period;
        tm_period[free_slot]   = period;
        tm_left[free_slot]     = cnt;
        tm_task[free_slot]     = tsk;
        tm_serial[free_slot]   = serial_ctr;
        pending_results.push_back({KIND_CREATED, 4'(free_slot), serial_ctr, 8'h00, 1'b1});
        serial_ctr = serial_ctr + 32'd1;
      end else begin
        pending_results.push_back({KIND_FULL, 4'h0, 32'h0, 8'h00, 1'b1});
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (n < MAX_RESULTS && tm_valid[i] && now >= tm_deadline[i]) begin
          tm_deadline[i] = now + tm_period[i];
          batch[n] = {KIND_FIRED, 4'(i), tm_serial[i], tm_task[i], 1'b0};
          n++;
          if (tm_left[i] == 8'd1) tm_valid[i] = 1'b0;
          else if (tm_left[i] != 8'd0) tm_left[i] = tm_left[i] - 8'd1;
        end
      end
      if (n == 0) begin
        pending_results.push_back({KIND_NONE, 4'h0, 32'h0, 8'h00, 1'b1});
      end else begin
        batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) pending_results.push_back(batch[k]);
      end
    end
  endtask

  // one beat: held until the block is free, predicted ahead of the accepting edge
  task automatic send_beat(opcode_t op, logic [63:0] now, logic [63:0] period,
                           logic [7:0] cnt, logic [7:0] tsk);
    @(negedge clk);
    start           <= 1'b1;
    in_opcode       <= op;
    in_now          <= now;
    in_period       <= period;
    in_repeat_count <= cnt;
    in_task_number  <= tsk;
    while (busy) @(negedge clk);
    predict_timers(op, now, period, cnt, tsk);
    @(posedge clk);
  endtask

  task automatic idle_gap();
    int unsigned len;
    if (idle_enable && $urandom_range(99) < 18) begin
      len = $urandom_range(1, 24);
      repeat (len) begin
        @(negedge clk);
        start     <= 1'b0;
        in_opcode <= 1'($urandom);
        in_now    <= {$urandom, $urandom};
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none actual kind %0d slot %0d serial %0h task %0h",
                 $time, out_kind, out_slot, out_serial_id, out_fired_task);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("slot", 32'(want.slot), 32'(out_slot));
        check_field("serial_id", want.serial, out_serial_id);
        check_field("fired_task", 32'(want.task_num), 32'(out_fired_task));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  task automatic test_empty_check();
    send_beat(OP_CHECK, 64'd0, 64'd0, 8'd0, 8'd0);
    idle_gap();
    send_beat(OP_CHECK, TICK_MAX, TICK_MAX, 8'hFF, 8'hFF);
  endtask

  task automatic test_create_extremes();
    send_beat(OP_CREATE, 64'd0, 64'd0, 8'd1, 8'h00);
    idle_gap();
    // deadline wraps to zero, so fires early
    send_beat(OP_CREATE, TICK_MAX, 64'd1, 8'd0, 8'hFF);
    send_beat(OP_CREATE, 64'd0, TICK_MAX, 8'hFF, 8'hA5);
    idle_gap();
    send_beat(OP_CREATE, 64'd100, 64'd50, 8'd2, 8'h5A);
  endtask

  task automatic test_fire_and_reload();
    send_beat(OP_CHECK, 64'd0, 64'd0, 8'd0, 8'd0);
    idle_gap();
    send_beat(OP_CHECK, TICK_MAX, 64'd0, 8'd0, 8'd0);
  endtask

  task automatic test_fill_table();
    for (int i = 0; i < 15; i++) begin
      send_beat(OP_CREATE, 64'(i), 64'(i * 3), 8'd1, 8'(i + 16));
      idle_gap();
    end
    // every slot fires in one check
    send_beat(OP_CHECK, TICK_MAX, 64'd0, 8'd0, 8'd0);
  endtask

  task automatic test_random_traffic();
    logic [63:0] now;
    logic [63:0] period;
    logic [7:0]  cnt;
    int unsigned r;
    for (int item = 0; item < 300; item++) begin
      idle_enable = !(item >= 120 && item < 200);
      r = $urandom_range(99);
      if (r < 45) begin
        r = $urandom_range(99);
        if (r < 5) period = 64'd0;
        else if (r < 10) period = {$urandom, $urandom};
        else period = 64'($urandom_range(1, 40));
        r = $urandom_range(99);
        if (r < 3) cnt = 8'd0;
        else if (r < 8) cnt = 8'($urandom);
        else cnt = 8'($urandom_range(1, 4));
        send_beat(OP_CREATE, tick, period, cnt, 8'($urandom));
      end else begin
        if ($urandom_range(99) < 5) tick = {$urandom, $urandom};
        else tick = tick + 64'($urandom_range(0, 30));
        now = tick;
        send_beat(OP_CHECK, now, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      end
      idle_gap();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = 1'b0;
    in_now          = '0;
    in_period       = '0;
    in_repeat_count = '0;
    in_task_number  = '0;
    mismatch_count  = 0;
    serial_ctr      = '0;
    idle_enable     = 1'b1;
    tick            = 64'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tm_valid[i]    = 1'b0;
      tm_deadline[i] = '0;
      tm_period[i]   = '0;
      tm_left[i]     = '0;
      tm_task[i]     = '0;
      tm_serial[i]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_check();
    test_create_extremes();
    test_fire_and_reload();
    test_fill_table();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 3) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ptb_pkg.sv
hw/rtl/ptb_cell.sv
hw/rtl/periodic_timer_bank_core.sv
tb/sv/tb_top.sv
